/* design/ptsu_pkg.sv */
// Shared types and constants for the preemptive task scheduler.
package ptsu_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned WaitW = 33;
  localparam int unsigned ProdW = 49;

  localparam logic [1:0] POL_PRIO = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_HRRN = 2'd2;

  localparam logic signed [15:0] PRIO_FLOOR = 16'sh8000;

  typedef struct packed {
    logic [31:0]        arrival;
    logic signed [15:0] prio;
    logic [15:0]        used;
    logic [15:0]        need;
  } ent_t;

  typedef struct packed {
    logic load;
    logic add;
    logic run_rd;
    logic run_cap;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic out_free;
    logic scan_last;
  } stat_t;

endpackage

/* design/preemptive_task_scheduler_unit.sv */
// An add beat passes the add state; a tick beat passes run read, run wait, scan,
// drain, decide and update, the scan reading one entry per cycle. A new beat is
// taken only in idle; a full output register stalls the add and update states.
// A finished result waits in the output register while the next beat enters.
// Reset (async, active low) frees all slots, clears the running task, time
// and policy; the task table itself needs no clearing pass.
module preemptive_task_scheduler_unit
  import ptsu_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,    // policy
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // task_slot, need_time, start_priority
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // accepted, run_valid, run_slot, finished,
                                      // finish_time, now_time
);

  cmd_t  cmd;
  stat_t stat;

  ptsu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ptsu_dp #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

/* design/ptsu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* design/ptsu_ctrl.sv */
// Sequencer for add and tick items of the task scheduler.
module ptsu_ctrl
  import ptsu_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_RUNRD  = 4'd2;
  localparam logic [3:0] S_RUNWT  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DRAIN1 = 4'd5;
  localparam logic [3:0] S_DRAIN2 = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_UPD    = 4'd8;

  logic [3:0] state_q, state_d;

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.op ? S_RUNRD : S_ADD;
        end
      end
      S_ADD: begin
        if (stat_i.out_free) begin
          cmd_o.add = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_RUNRD: begin
        cmd_o.run_rd = 1'b1;
        state_d      = S_RUNWT;
      end
      S_RUNWT: begin
        cmd_o.run_cap    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN1;
        end
      end
      S_DRAIN1: state_d = S_DRAIN2;
      S_DRAIN2: state_d = S_DECIDE;
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        if (stat_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/ptsu_dp.sv */
// Datapath: task table, selection pipeline, running task and result register.
module ptsu_dp
  import ptsu_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  input  cmd_t        cmd_i,
  output stat_t       stat_o
);

  localparam int unsigned SW = $clog2(TASK_SLOTS);

  logic [1:0]         policy_q;
  logic [TimeW-1:0]   time_q;
  logic [2:0]         in_slot_q;
  logic [15:0]        in_need_q;
  logic signed [15:0] in_prio_q;
  logic [TASK_SLOTS-1:0] busy_q;
  logic               run_vld_q;
  logic [SW-1:0]      run_slot_q;

  logic [SW-1:0]      scan_idx_q;
  logic               p1_vld_q;
  logic [SW-1:0]      p1_slot_q;
  logic               p2_vld_q;
  logic [SW-1:0]      p2_slot_q;
  ent_t               cand_q;
  logic [WaitW-1:0]   cand_wait_q;

  logic               best_vld_q;
  logic [SW-1:0]      best_slot_q;
  ent_t               best_q;
  logic [WaitW-1:0]   best_wait_q;
  ent_t               run_q;
  logic [WaitW-1:0]   run_wait_q;

  logic               sel_vld_q;
  logic [SW-1:0]      sel_slot_q;
  ent_t               sel_q;

  logic               out_vld_q;
  logic [71:0]        out_data_q;

  ent_t               ram_rdata;
  ent_t               ram_wdata;
  logic               ram_we;
  logic [SW-1:0]      ram_waddr;
  logic               ram_re;
  logic [SW-1:0]      ram_raddr;

  logic [SW-1:0]      add_idx;
  logic               add_ok;
  logic [WaitW-1:0]   rd_wait;
  logic               p1_ready;

  ent_t               cmp_a, cmp_b;
  logic [WaitW-1:0]   cmp_a_wait, cmp_b_wait;
  logic [ProdW-1:0]   prod_a, prod_b;
  logic               a_better;

  logic signed [15:0] upd_prio;
  logic [15:0]        upd_used;
  logic               upd_fin;
  ent_t               upd_ent;
  logic               out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  assign stat_o.op        = s_axis_tuser;
  assign stat_o.out_free  = out_free;
  assign stat_o.scan_last = (scan_idx_q == SW'(TASK_SLOTS - 1));

  assign add_idx = SW'(in_slot_q);
  assign add_ok  = (32'(in_slot_q) < TASK_SLOTS) && !busy_q[add_idx] && (in_need_q != 16'd0);

  assign rd_wait  = {1'b0, time_q - ram_rdata.arrival} + WaitW'(1);
  assign p1_ready = p1_vld_q && busy_q[p1_slot_q] && !(run_vld_q && (p1_slot_q == run_slot_q));

  // The comparator serves the scan (candidate against best) and the final
  // preemption check (best against the running task).
  always_comb begin
    if (cmd_i.decide) begin
      cmp_a      = best_q;
      cmp_a_wait = best_wait_q;
      cmp_b      = run_q;
      cmp_b_wait = run_wait_q;
    end else begin
      cmp_a      = cand_q;
      cmp_a_wait = cand_wait_q;
      cmp_b      = best_q;
      cmp_b_wait = best_wait_q;
    end
  end

  assign prod_a = ProdW'(cmp_a.need) * ProdW'(cmp_b_wait);
  assign prod_b = ProdW'(cmp_b.need) * ProdW'(cmp_a_wait);

  always_comb begin
    unique case (policy_q)
      POL_SJF:  a_better = cmp_a.need < cmp_b.need;
      POL_HRRN: a_better = prod_a > prod_b;
      default:  a_better = cmp_a.prio > cmp_b.prio;
    endcase
  end

  assign upd_prio = (sel_q.prio == PRIO_FLOOR) ? sel_q.prio : sel_q.prio - 16'sd1;
  assign upd_used = sel_q.used + 16'd1;
  assign upd_fin  = (upd_used == sel_q.need);

  always_comb begin
    upd_ent      = sel_q;
    upd_ent.prio = upd_prio;
    upd_ent.used = upd_used;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sel_slot_q;
    ram_wdata = upd_ent;
    if (cmd_i.add && add_ok) begin
      ram_we            = 1'b1;
      ram_waddr         = add_idx;
      ram_wdata.need    = in_need_q;
      ram_wdata.used    = 16'd0;
      ram_wdata.prio    = in_prio_q;
      ram_wdata.arrival = time_q;
    end else if (cmd_i.upd && sel_vld_q) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re    = cmd_i.run_rd || cmd_i.scan_step;
  assign ram_raddr = cmd_i.run_rd ? run_slot_q : scan_idx_q;

  ptsu_ram #(
    .WIDTH($bits(ent_t)),
    .DEPTH(TASK_SLOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_slot_q <= s_axis_tdata[2:0];
      in_need_q <= s_axis_tdata[18:3];
      in_prio_q <= s_axis_tdata[34:19];
    end
    p1_slot_q <= scan_idx_q;
    if (p1_vld_q) begin
      p2_slot_q   <= p1_slot_q;
      cand_q      <= ram_rdata;
      cand_wait_q <= rd_wait;
    end
    if (cmd_i.run_cap) begin
      run_q      <= ram_rdata;
      run_wait_q <= rd_wait;
    end
    if (p2_vld_q && (!best_vld_q || a_better)) begin
      best_slot_q <= p2_slot_q;
      best_q      <= cand_q;
      best_wait_q <= cand_wait_q;
    end
    if (cmd_i.decide) begin
      if (run_vld_q && !(best_vld_q && a_better)) begin
        sel_slot_q <= run_slot_q;
        sel_q      <= run_q;
      end else begin
        sel_slot_q <= best_slot_q;
        sel_q      <= best_q;
      end
    end
    if (cmd_i.add) begin
      out_data_q <= {2'b00, time_q, 32'd0, 1'b0, 3'd0, 1'b0, add_ok};
    end else if (cmd_i.upd) begin
      out_data_q <= {2'b00,
                     time_q,
                     (sel_vld_q && upd_fin) ? time_q + 32'd1 : 32'd0,
                     sel_vld_q && upd_fin,
                     sel_vld_q ? 3'(sel_slot_q) : 3'd0,
                     sel_vld_q,
                     1'b0};
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= POL_PRIO;
      time_q     <= '0;
      busy_q     <= '0;
      run_vld_q  <= 1'b0;
      run_slot_q <= '0;
      scan_idx_q <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      sel_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        policy_q <= cfg_wdata_i;
      end
      p1_vld_q <= cmd_i.scan_step;
      p2_vld_q <= p1_ready;
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
        best_vld_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= stat_o.scan_last ? '0 : scan_idx_q + SW'(1);
      end
      if (p2_vld_q) begin
        best_vld_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        sel_vld_q <= run_vld_q || best_vld_q;
      end
      if (cmd_i.add && add_ok) begin
        busy_q[add_idx] <= 1'b1;
      end
      if (cmd_i.upd) begin
        time_q <= time_q + 32'd1;
        if (sel_vld_q) begin
          run_slot_q <= sel_slot_q;
          run_vld_q  <= !upd_fin;
          if (upd_fin) begin
            busy_q[sel_slot_q] <= 1'b0;
          end
        end
      end
      if (cmd_i.add || cmd_i.upd) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* tb/tb_preemptive_task_scheduler_unit.sv */
// Testbench for the preemptive task scheduler: directed and random adds and ticks checked against a predictor.
module tb_preemptive_task_scheduler_unit;
  import ptsu_pkg::*;

  // Members run from the highest bits down, so now_time sits in the top field.
  typedef struct packed {
    logic [31:0] now_time;
    logic [31:0] finish_time;
    logic        finished;
    logic [2:0]  run_slot;
    logic        run_valid;
    logic        accepted;
  } sched_res_t;

  class sched_scoreboard;
    bit               busy[8];
    logic [15:0]      need[8];
    logic [15:0]      used[8];
    logic signed [15:0] prio[8];
    logic [31:0]      arrival[8];
    int               running;
    logic [31:0]      now;
    logic [1:0]       policy;
    sched_res_t       pending[$];
    int               errors;

    function new();
      running = 8;
      now = 0;
      policy = POL_PRIO;
      errors = 0;
      foreach (busy[i]) busy[i] = 0;
    endfunction

    function logic [32:0] wait_of(int s);
      logic [31:0] d;
      d = now - arrival[s];
      return {1'b0, d} + 33'd1;
    endfunction

    function bit beats(int a, int b);
      logic [48:0] pa, pb;
      if (policy == POL_SJF) return need[a] < need[b];
      if (policy == POL_HRRN) begin
        pa = need[a] * wait_of(b);
        pb = need[b] * wait_of(a);
        return pa > pb;
      end
      return prio[a] > prio[b];
    endfunction

    function void note_item(logic op, logic [2:0] slot, logic [15:0] nd,
                            logic signed [15:0] pr);
      sched_res_t r;
      int best, k;
      r = '0;
      r.now_time = now;
      if (!op) begin
        if (!busy[slot] && nd != 0) begin
          busy[slot] = 1; need[slot] = nd; used[slot] = 16'd0;
          prio[slot] = pr; arrival[slot] = now; r.accepted = 1;
        end
      end else begin
        best = 8;
        for (int i = 0; i < 8; i++) begin
          if (!busy[i] || i == running) continue;
          if (best == 8 || beats(i, best)) best = i;
        end
        if (best < 8 && (running == 8 || beats(best, running))) running = best;
        if (running < 8) begin
          k = running;
          r.run_valid = 1;
          r.run_slot = k[2:0];
          if (prio[k] != PRIO_FLOOR) prio[k] = prio[k] - 16'sd1;
          used[k] = used[k] + 16'd1;
          if (used[k] == need[k]) begin
            r.finished = 1; r.finish_time = now + 32'd1;
            busy[k] = 0; running = 8;
          end
        end
        now = now + 32'd1;
      end
      pending.push_back(r);
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h actual %h", e, got);
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [1:0]  cfg_wdata_i = 0;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [39:0] s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [71:0] m_axis_tdata;

  sched_scoreboard sb;
  int send_idle = 0, recv_stall = 0;
  int quiet = 0;

  preemptive_task_scheduler_unit dut (.*);

  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata[69:0]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) quiet = 0;
      else quiet++;
      if (quiet > 20000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= recv_stall);

  // The beat stays on the bus after acceptance until the next item or a drain replaces it.
  task automatic send_item(logic op, logic [2:0] slot, logic [15:0] nd, logic [15:0] pr);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= op;
    s_axis_tdata <= {5'd0, pr, nd, slot};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_item(op, slot, nd, pr);
    @(negedge clk_i);
  endtask

  task automatic tick_item();
    send_item(1'b1, 3'd0, 16'd0, 16'd0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_policy(logic [1:0] p);
    drain();
    cfg_we_i <= 1; cfg_wdata_i <= p;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.policy = p;
  endtask

  task automatic random_item();
    logic [15:0] nd;
    int r;
    r = $urandom_range(99);
    nd = (r < 80) ? 16'($urandom_range(6, 1)) : (r < 90 ? 16'(0) : 16'($urandom));
    if ($urandom_range(99) < 55) tick_item();
    else send_item(1'b0, 3'($urandom_range(7)), nd, 16'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // Directed: extremes, busy-slot and zero-need rejects, idle tick, priority floor.
    tick_item();
    send_item(1'b0, 3'd0, 16'd3, 16'h8000);
    send_item(1'b0, 3'd0, 16'd2, 16'h7fff);
    send_item(1'b0, 3'd7, 16'd0, 16'h0000);
    send_item(1'b0, 3'd7, 16'hffff, 16'h7fff);
    send_item(1'b0, 3'd3, 16'd1, 16'hffff);
    repeat (6) tick_item();
    set_policy(POL_SJF);
    send_item(1'b0, 3'd1, 16'd2, 16'h0000);
    repeat (4) tick_item();
    set_policy(POL_HRRN);
    send_item(1'b0, 3'd2, 16'd5, 16'h1234);
    repeat (4) tick_item();
    set_policy(2'd3);
    repeat (3) tick_item();
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(2'(ph % 4));
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 86; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 86; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n == 100) drain();
        random_item();
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

/* preemptive_task_scheduler_unit.f */
design/ptsu_pkg.sv
design/ptsu_ram.sv
design/ptsu_ctrl.sv
design/ptsu_dp.sv
design/preemptive_task_scheduler_unit.sv
tb/tb_preemptive_task_scheduler_unit.sv
